// File: rtl/sgad_pkg.sv
`timescale 1ns / 1ps

package sgad_pkg;

	localparam int unsigned StickW     = 12;
	localparam int unsigned HoldW      = 10;
	localparam int unsigned SwingW     = 3;
	localparam int unsigned ArmCountW  = 11;
	localparam int unsigned CfgIndexW  = 2;
	localparam int unsigned CfgDataW   = 10;

	// Stick thresholds in microseconds
	localparam logic [StickW-1:0] YawArmMax      = 12'd1300;
	localparam logic [StickW-1:0] ThrottleLowMax = 12'd1200;
	localparam logic [StickW-1:0] PitchArmMax    = 12'd1300;
	localparam logic [StickW-1:0] RollArmMin     = 12'd1700;
	localparam logic [StickW-1:0] YawDisarmMin   = 12'd1700;
	localparam logic [StickW-1:0] RollLeftMin    = 12'd1750;
	localparam logic [StickW-1:0] RollRightMax   = 12'd1250;

	// Register reset values
	localparam logic [HoldW-1:0]  ArmHoldReset    = 10'd100;
	localparam logic [HoldW-1:0]  DisarmHoldReset = 10'd50;
	localparam logic [SwingW-1:0] CalibSwingReset = 3'd3;

	// Register indexes
	localparam logic [CfgIndexW-1:0] RegArmHold    = 2'd0;
	localparam logic [CfgIndexW-1:0] RegDisarmHold = 2'd1;
	localparam logic [CfgIndexW-1:0] RegCalibSwing = 2'd2;

	typedef struct packed {
		logic [HoldW-1:0]  arm_hold_ticks;
		logic [HoldW-1:0]  disarm_hold_ticks;
		logic [SwingW-1:0] calib_swings;
	} cfg_t;

	typedef struct packed {
		logic                 armed_flag;
		logic [ArmCountW-1:0] arm_tick_count;
		logic [HoldW-1:0]     disarm_tick_count;
		logic [SwingW-1:0]    left_swing_count;
		logic [SwingW-1:0]    right_swing_count;
		logic                 arm_pose_flag;
		logic                 disarm_pose_flag;
	} state_t;

	typedef struct packed {
		logic armed;
		logic arm_event;
		logic disarm_event;
		logic calibrate_event;
		logic arm_pose_held;
		logic disarm_pose_held;
	} result_t;

	typedef struct packed {
		logic [StickW-1:0] roll;
		logic [StickW-1:0] pitch;
		logic [StickW-1:0] throttle;
		logic [StickW-1:0] yaw;
	} sticks_t;

endpackage

// File: rtl/sgad_cfg.sv
`timescale 1ns / 1ps

module sgad_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sgad_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [sgad_pkg::CfgDataW-1:0]   cfg_data,
	output sgad_pkg::cfg_t                  cfg
);

	sgad_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Ignore writes to indexes past the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_hold_ticks    <= sgad_pkg::ArmHoldReset;
			cfg_q.disarm_hold_ticks <= sgad_pkg::DisarmHoldReset;
			cfg_q.calib_swings      <= sgad_pkg::CalibSwingReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sgad_pkg::RegArmHold: begin
					cfg_q.arm_hold_ticks <= cfg_data[sgad_pkg::HoldW-1:0];
				end
				sgad_pkg::RegDisarmHold: begin
					cfg_q.disarm_hold_ticks <= cfg_data[sgad_pkg::HoldW-1:0];
				end
				sgad_pkg::RegCalibSwing: begin
					cfg_q.calib_swings <= cfg_data[sgad_pkg::SwingW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/sgad_core.sv
`timescale 1ns / 1ps

module sgad_core (
	input  sgad_pkg::cfg_t    cfg,
	input  sgad_pkg::state_t  cur,
	input  sgad_pkg::sticks_t sticks,
	output sgad_pkg::state_t  nxt,
	output sgad_pkg::result_t res
);

	localparam logic [sgad_pkg::SwingW-1:0]    SwingMax  = '1;
	localparam logic [sgad_pkg::ArmCountW-1:0] ArmMax    = '1;
	localparam logic [sgad_pkg::HoldW-1:0]     DisarmMax = '1;

	logic [sgad_pkg::SwingW-1:0] left_c, right_c;
	logic                        cal_ev;
	logic [sgad_pkg::ArmCountW-1:0] arm_cnt_a;
	logic                        arm_flag_a, armed_a, arm_ev;
	logic [sgad_pkg::HoldW-1:0]  dis_cnt_d;
	logic                        dis_flag_d, armed_d, dis_ev;

	// Calibrate swings
	always_comb begin
		left_c  = cur.left_swing_count;
		right_c = cur.right_swing_count;
		cal_ev  = 1'b0;
		if (!cur.armed_flag) begin
			if (sticks.roll > sgad_pkg::RollLeftMin && left_c == right_c) begin
				left_c = (left_c < SwingMax) ? left_c + 1'b1 : SwingMax;
			end
			if (sticks.roll < sgad_pkg::RollRightMax && left_c > right_c) begin
				right_c = (right_c < SwingMax) ? right_c + 1'b1 : SwingMax;
			end
			if (left_c == cfg.calib_swings && right_c == cfg.calib_swings) begin
				cal_ev  = 1'b1;
				left_c  = '0;
				right_c = '0;
			end
		end
	end

	// Arming pose; a partial pose holds count and flag
	always_comb begin
		arm_cnt_a  = cur.arm_tick_count;
		arm_flag_a = cur.arm_pose_flag;
		armed_a    = cur.armed_flag;
		arm_ev     = 1'b0;
		if (!cur.armed_flag) begin
			if (sticks.yaw < sgad_pkg::YawArmMax &&
			    sticks.throttle < sgad_pkg::ThrottleLowMax) begin
				if (sticks.pitch < sgad_pkg::PitchArmMax &&
				    sticks.roll > sgad_pkg::RollArmMin) begin
					arm_flag_a = 1'b1;
					arm_cnt_a  = (arm_cnt_a < ArmMax) ? arm_cnt_a + 1'b1 : ArmMax;
				end
			end else begin
				arm_flag_a = 1'b0;
				arm_cnt_a  = '0;
			end
			if (arm_cnt_a > {1'b0, cfg.arm_hold_ticks}) begin
				arm_cnt_a  = '0;
				arm_flag_a = 1'b0;
				armed_a    = 1'b1;
				arm_ev     = 1'b1;
			end
		end
	end

	// Disarming pose, seen with the armed state the arm check leaves
	always_comb begin
		dis_cnt_d  = cur.disarm_tick_count;
		dis_flag_d = cur.disarm_pose_flag;
		armed_d    = armed_a;
		dis_ev     = 1'b0;
		if (armed_a) begin
			if (sticks.yaw > sgad_pkg::YawDisarmMin &&
			    sticks.throttle < sgad_pkg::ThrottleLowMax) begin
				dis_flag_d = 1'b1;
				dis_cnt_d  = (dis_cnt_d < DisarmMax) ? dis_cnt_d + 1'b1 : DisarmMax;
			end else begin
				dis_flag_d = 1'b0;
				dis_cnt_d  = '0;
			end
			if (dis_cnt_d == cfg.disarm_hold_ticks) begin
				dis_cnt_d  = '0;
				dis_flag_d = 1'b0;
				armed_d    = 1'b0;
				dis_ev     = 1'b1;
			end
		end
	end

	always_comb begin
		nxt.armed_flag        = armed_d;
		nxt.arm_tick_count    = arm_cnt_a;
		nxt.disarm_tick_count = dis_cnt_d;
		nxt.left_swing_count  = left_c;
		nxt.right_swing_count = right_c;
		nxt.arm_pose_flag     = arm_flag_a;
		nxt.disarm_pose_flag  = dis_flag_d;

		res.armed            = armed_d;
		res.arm_event        = arm_ev;
		res.disarm_event     = dis_ev;
		res.calibrate_event  = cal_ev;
		res.arm_pose_held    = arm_flag_a;
		res.disarm_pose_held = dis_flag_d;
	end

endmodule

// File: rtl/stick_gesture_arm_disarm_detector.sv
`timescale 1ns / 1ps

// Stick gesture arm/disarm detector.
// Input channel: in_valid / in_stall with one control tick of four stick pulse
// widths (roll, pitch, throttle, yaw). A request is taken at a clock edge with
// in_valid high and in_stall low.
// Output channel: out_valid / out_stall with one result per tick: armed state,
// arm, disarm and calibrate events, and the two pose-held flags.
// Configuration: cfg_valid / cfg_ready write channel, cfg_index selects arm
// hold (0), disarm hold (1) or calibration swing count (2); other indexes are
// dropped. cfg_ready is always high. Write only while the block is idle.
// Path: a request is registered in the input stage, evaluated against the
// gesture state in one pass and loaded into the output register as it leaves
// the input stage, which waits while a stalled result fills the output register.
// Throughput is one tick per cycle while out_stall is low; the gesture state
// register updates as a tick leaves the input stage, so back-to-back ticks chain.
// Reset (arst_n low, asynchronous): disarmed, all counters and flags cleared,
// registers back to 100 / 50 / 3, both stages empty.
// Stall: while out_stall holds a valid result, the input stage holds its tick
// and in_stall rises once that stage is full; no request is lost.

module stick_gesture_arm_disarm_detector (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sgad_pkg::StickW-1:0]    roll_stick,
	input  logic [sgad_pkg::StickW-1:0]    pitch_stick,
	input  logic [sgad_pkg::StickW-1:0]    throttle_stick,
	input  logic [sgad_pkg::StickW-1:0]    yaw_stick,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           armed,
	output logic                           arm_event,
	output logic                           disarm_event,
	output logic                           calibrate_event,
	output logic                           arm_pose_held,
	output logic                           disarm_pose_held,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sgad_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [sgad_pkg::CfgDataW-1:0]  cfg_data
);

	sgad_pkg::cfg_t    cfg;
	sgad_pkg::state_t  state_q, state_nxt;
	sgad_pkg::sticks_t sticks_s1;
	sgad_pkg::result_t res_nxt, res_s2;
	logic              valid_s1, valid_s2;
	logic              advance_s1;

	sgad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sgad_core u_core (
		.cfg    (cfg),
		.cur    (state_q),
		.sticks (sticks_s1),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// Move the input stage on whenever the output register is free or draining
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input stage: take a new request whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			sticks_s1.roll     <= roll_stick;
			sticks_s1.pitch    <= pitch_stick;
			sticks_s1.throttle <= throttle_stick;
			sticks_s1.yaw      <= yaw_stick;
		end
	end

	// Gesture state commits exactly once per tick, as it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign armed            = res_s2.armed;
	assign arm_event        = res_s2.arm_event;
	assign disarm_event     = res_s2.disarm_event;
	assign calibrate_event  = res_s2.calibrate_event;
	assign arm_pose_held    = res_s2.arm_pose_held;
	assign disarm_pose_held = res_s2.disarm_pose_held;

endmodule

// File: tb/sv/stick_gesture_arm_disarm_detector_tb.sv
`timescale 1ns / 1ps

// Stimulus runs in three stages:
//   - directed ticks at the reset register values, placed on the stick thresholds
//   - three phases at other hold settings: a 61-tick arm and 40-tick disarm hold,
//     zero holds, under which the arming tick also disarms, a lowered disarm
//     hold and zero swing count
//   - random phases of well-formed gestures with random content, mixed with noise
// Every accepted tick is run through a local copy of the gesture state. The
// resulting flags are queued and compared with the block's results in order.
module stick_gesture_arm_disarm_detector_tb;

	// Index 3 selects no register; the block must drop the write
	localparam logic [sgad_pkg::CfgIndexW-1:0] RegSpare = 2'd3;
	localparam int unsigned StallLimit    = 1000;
	localparam int unsigned SqueezeCycles = 40;
	localparam int unsigned PhaseTicks    = 65;

	typedef enum {TkAny, TkArm, TkPartial, TkDisarm, TkLeft, TkRight, TkRest} tick_kind_t;

	logic                                clk            = 1'b0;
	logic                                arst_n         = 1'b0;
	logic                                in_valid       = 1'b0;
	logic                                in_stall;
	logic [sgad_pkg::StickW-1:0]         roll_stick     = '0;
	logic [sgad_pkg::StickW-1:0]         pitch_stick    = '0;
	logic [sgad_pkg::StickW-1:0]         throttle_stick = '0;
	logic [sgad_pkg::StickW-1:0]         yaw_stick      = '0;
	logic                                out_valid;
	logic                                out_stall      = 1'b0;
	logic                                armed;
	logic                                arm_event;
	logic                                disarm_event;
	logic                                calibrate_event;
	logic                                arm_pose_held;
	logic                                disarm_pose_held;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [sgad_pkg::CfgIndexW-1:0]      cfg_index = '0;
	logic [sgad_pkg::CfgDataW-1:0]       cfg_data  = '0;

	// Pending requests, and the flags each accepted request should produce
	sgad_pkg::sticks_t tick_q[$];
	sgad_pkg::result_t expected_flags_q[$];

	// Local copy of the gesture state and the hold registers
	sgad_pkg::state_t  gesture;
	sgad_pkg::cfg_t    hold_cfg;
	sgad_pkg::sticks_t on_bus;
	sgad_pkg::result_t want;

	int unsigned ticks_sent;
	int unsigned results_seen;
	int unsigned err_count;
	int unsigned settings_used;
	int unsigned arm_seen;
	int unsigned disarm_seen;
	int unsigned calib_seen;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned hold_left;
	int unsigned idle_cycles;
	bit          squeeze_done;
	logic        quiet       = 1'b0;
	logic        squeeze_req = 1'b0;

	stick_gesture_arm_disarm_detector uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.roll_stick       (roll_stick),
		.pitch_stick      (pitch_stick),
		.throttle_stick   (throttle_stick),
		.yaw_stick        (yaw_stick),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.armed            (armed),
		.arm_event        (arm_event),
		.disarm_event     (disarm_event),
		.calibrate_event  (calibrate_event),
		.arm_pose_held    (arm_pose_held),
		.disarm_pose_held (disarm_pose_held),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the gesture state by one tick: swing check, then arm check, then
	// disarm check against whatever the arm check left behind.
	function automatic sgad_pkg::result_t step_gesture(sgad_pkg::sticks_t s);
		sgad_pkg::result_t r;
		r = '0;
		if (!gesture.armed_flag) begin
			// A left swing only counts while the two counts are level, a right
			// swing only while left is ahead; both stop at 7
			if (s.roll > sgad_pkg::RollLeftMin
					&& gesture.left_swing_count == gesture.right_swing_count
					&& gesture.left_swing_count != '1)
				gesture.left_swing_count += 1'b1;
			if (s.roll < sgad_pkg::RollRightMax
					&& gesture.left_swing_count > gesture.right_swing_count
					&& gesture.right_swing_count != '1)
				gesture.right_swing_count += 1'b1;
			if (gesture.left_swing_count == hold_cfg.calib_swings
					&& gesture.right_swing_count == hold_cfg.calib_swings) begin
				r.calibrate_event = 1'b1;
				gesture.left_swing_count = '0;
				gesture.right_swing_count = '0;
			end
		end
		if (!gesture.armed_flag) begin
			if (s.yaw < sgad_pkg::YawArmMax && s.throttle < sgad_pkg::ThrottleLowMax) begin
				// With pitch or roll out of place, hold count and flag as they are
				if (s.pitch < sgad_pkg::PitchArmMax && s.roll > sgad_pkg::RollArmMin) begin
					gesture.arm_pose_flag = 1'b1;
					if (gesture.arm_tick_count != '1)
						gesture.arm_tick_count += 1'b1;
				end
			end else begin
				gesture.arm_pose_flag = 1'b0;
				gesture.arm_tick_count = '0;
			end
			if (gesture.arm_tick_count > hold_cfg.arm_hold_ticks) begin
				gesture.arm_tick_count = '0;
				gesture.arm_pose_flag = 1'b0;
				gesture.armed_flag = 1'b1;
				r.arm_event = 1'b1;
			end
		end
		if (gesture.armed_flag) begin
			if (s.yaw > sgad_pkg::YawDisarmMin && s.throttle < sgad_pkg::ThrottleLowMax) begin
				gesture.disarm_pose_flag = 1'b1;
				if (gesture.disarm_tick_count != '1)
					gesture.disarm_tick_count += 1'b1;
			end else begin
				gesture.disarm_pose_flag = 1'b0;
				gesture.disarm_tick_count = '0;
			end
			// Exact match: a count already past the hold never disarms
			if (gesture.disarm_tick_count == hold_cfg.disarm_hold_ticks) begin
				gesture.disarm_tick_count = '0;
				gesture.disarm_pose_flag = 1'b0;
				gesture.armed_flag = 1'b0;
				r.disarm_event = 1'b1;
			end
		end
		r.armed = gesture.armed_flag;
		r.arm_pose_held = gesture.arm_pose_flag;
		r.disarm_pose_held = gesture.disarm_pose_flag;
		return r;
	endfunction

	function automatic sgad_pkg::sticks_t stick_tick(logic [sgad_pkg::StickW-1:0] r,
			logic [sgad_pkg::StickW-1:0] p, logic [sgad_pkg::StickW-1:0] t,
			logic [sgad_pkg::StickW-1:0] y);
		sgad_pkg::sticks_t s;
		s.roll = r;
		s.pitch = p;
		s.throttle = t;
		s.yaw = y;
		return s;
	endfunction

	// Random stick value in a range, cut to the stick width
	function automatic logic [sgad_pkg::StickW-1:0] rand_stick(int unsigned lo,
			int unsigned hi);
		return sgad_pkg::StickW'($urandom_range(lo, hi));
	endfunction

	// Random stick value within two units of a threshold
	function automatic logic [sgad_pkg::StickW-1:0] around(logic [sgad_pkg::StickW-1:0] th);
		return sgad_pkg::StickW'(th - 2 + $urandom_range(0, 4));
	endfunction

	// Random tick of the given shape; fields the shape does not fix stay random
	function automatic sgad_pkg::sticks_t make_tick(tick_kind_t k);
		sgad_pkg::sticks_t t;
		t = stick_tick(rand_stick(0, 4095), rand_stick(0, 4095),
			rand_stick(0, 4095), rand_stick(0, 4095));
		case (k)
		TkArm: begin
			t.roll = rand_stick(sgad_pkg::RollArmMin + 1, 4095);
			t.pitch = rand_stick(0, sgad_pkg::PitchArmMax - 1);
			t.throttle = rand_stick(0, sgad_pkg::ThrottleLowMax - 1);
			t.yaw = rand_stick(0, sgad_pkg::YawArmMax - 1);
		end
		TkPartial: begin
			// Yaw and throttle in place, pitch or roll not
			t.throttle = rand_stick(0, sgad_pkg::ThrottleLowMax - 1);
			t.yaw = rand_stick(0, sgad_pkg::YawArmMax - 1);
			if ($urandom_range(0, 1))
				t.pitch = rand_stick(sgad_pkg::PitchArmMax, 4095);
			else
				t.roll = rand_stick(0, sgad_pkg::RollArmMin);
		end
		TkDisarm: begin
			t.throttle = rand_stick(0, sgad_pkg::ThrottleLowMax - 1);
			t.yaw = rand_stick(sgad_pkg::YawDisarmMin + 1, 4095);
		end
		TkLeft:  t.roll = rand_stick(sgad_pkg::RollLeftMin + 1, 4095);
		TkRight: t.roll = rand_stick(0, sgad_pkg::RollRightMax - 1);
		TkRest: begin
			// Roll centered, throttle up: releases both poses, no swing
			t.roll = rand_stick(sgad_pkg::RollRightMax, sgad_pkg::RollLeftMin);
			t.throttle = rand_stick(sgad_pkg::ThrottleLowMax, 4095);
		end
		default: ;
		endcase
		return t;
	endfunction

	task automatic add_ticks(tick_kind_t k, int unsigned n);
		repeat (n) tick_q.push_back(make_tick(k));
	endtask

	task automatic add_swings(int unsigned pairs);
		repeat (pairs) begin
			add_ticks(TkLeft, 1);
			if ($urandom_range(0, 2) == 0)
				add_ticks(TkRest, 1);
			add_ticks(TkRight, 1);
		end
	endtask

	// Append one random gesture, sized from the current hold registers
	task automatic add_burst();
		int unsigned n;
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			// Arming hold, now and then one tick short, with stray partial poses
			n = hold_cfg.arm_hold_ticks + 1;
			if ($urandom_range(0, 3) == 0)
				n--;
			repeat (n) begin
				if ($urandom_range(0, 7) == 0)
					add_ticks(TkPartial, 1);
				add_ticks(TkArm, 1);
			end
		end
		3, 4: begin
			// Disarm hold: one short, exact, or one over
			n = (hold_cfg.disarm_hold_ticks == 0) ? 4 : hold_cfg.disarm_hold_ticks;
			add_ticks(TkDisarm, n + $urandom_range(0, 2) - 1);
		end
		5, 6: begin
			n = (hold_cfg.calib_swings == 0) ? 2 : hold_cfg.calib_swings;
			add_swings(n + $urandom_range(0, 2) - 1);
		end
		7: add_ticks(TkAny, $urandom_range(1, 5));
		8: add_ticks(TkRest, $urandom_range(1, 3));
		default: begin
			tick_q.push_back(stick_tick(
				around($urandom_range(0, 1) ? sgad_pkg::RollArmMin
					: ($urandom_range(0, 1) ? sgad_pkg::RollLeftMin
					: sgad_pkg::RollRightMax)),
				around(sgad_pkg::PitchArmMax),
				around(sgad_pkg::ThrottleLowMax),
				around($urandom_range(0, 1) ? sgad_pkg::YawArmMax
					: sgad_pkg::YawDisarmMin)));
		end
		endcase
	endtask

	task automatic check_bit(string name, logic want_bit, logic got_bit);
		if (got_bit !== want_bit) begin
			$error("%s: expected %0b, got %0b", name, want_bit, got_bit);
			err_count++;
		end
	endtask

	// Write one register and mirror it; call only with nothing in flight
	task automatic write_reg(logic [sgad_pkg::CfgIndexW-1:0] idx,
			logic [sgad_pkg::CfgDataW-1:0] val);
		logic taken;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		// cfg_ready only moves on rising edges, so the value at the falling
		// edge says whether the next rising edge takes the write
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		case (idx)
		sgad_pkg::RegArmHold:    hold_cfg.arm_hold_ticks = val[sgad_pkg::HoldW-1:0];
		sgad_pkg::RegDisarmHold: hold_cfg.disarm_hold_ticks = val[sgad_pkg::HoldW-1:0];
		sgad_pkg::RegCalibSwing: hold_cfg.calib_swings = val[sgad_pkg::SwingW-1:0];
		default: ;
		endcase
	endtask

	task automatic set_config(logic [sgad_pkg::CfgDataW-1:0] arm_hold,
			logic [sgad_pkg::CfgDataW-1:0] disarm_hold,
			logic [sgad_pkg::CfgDataW-1:0] swings);
		write_reg(sgad_pkg::RegArmHold, arm_hold);
		write_reg(sgad_pkg::RegDisarmHold, disarm_hold);
		write_reg(sgad_pkg::RegCalibSwing, swings);
		settings_used++;
	endtask

	// Hold until every queued request is taken and every result is back
	task automatic wait_idle();
		do @(negedge clk);
		while (tick_q.size() != 0 || in_valid || expected_flags_q.size() != 0);
	endtask

	// Request driver: predict each accepted tick, then present the next one
	// unless an idle burst is running. The payload holds while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_flags_q.push_back(step_gesture(on_bus));
				ticks_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					on_bus = tick_q.pop_front();
					in_valid <= 1'b1;
					roll_stick <= on_bus.roll;
					pitch_stick <= on_bus.pitch;
					throttle_stick <= on_bus.throttle;
					yaw_stick <= on_bus.yaw;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted result against the oldest prediction,
	// then pick the stall for the next cycle. One long hold-off fills the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
			squeeze_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_flags_q.size() == 0) begin
					$error("result arrived with no tick waiting for it");
					err_count++;
				end else begin
					want = expected_flags_q.pop_front();
					check_bit("armed", want.armed, armed);
					check_bit("arm_event", want.arm_event, arm_event);
					check_bit("disarm_event", want.disarm_event, disarm_event);
					check_bit("calibrate_event", want.calibrate_event, calibrate_event);
					check_bit("arm_pose_held", want.arm_pose_held, arm_pose_held);
					check_bit("disarm_pose_held", want.disarm_pose_held, disarm_pose_held);
					arm_seen += want.arm_event;
					disarm_seen += want.disarm_event;
					calib_seen += want.calibrate_event;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left = SqueezeCycles - 1;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: drop the run when no handshake of any kind completes for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("watchdog: no handshake for %0d cycles", StallLimit);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		gesture = '0;
		hold_cfg = {sgad_pkg::ArmHoldReset, sgad_pkg::DisarmHoldReset,
			sgad_pkg::CalibSwingReset};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at reset values: thresholds from both sides, a full
		// three-pair swing sequence, partial arm poses, all-low and all-high sticks
		@(negedge clk);
		tick_q.push_back(stick_tick(12'd0, 12'd0, 12'd0, 12'd0));
		tick_q.push_back(stick_tick(12'd4095, 12'd4095, 12'd4095, 12'd4095));
		tick_q.push_back(stick_tick(12'd1250, 12'd2000, 12'd2000, 12'd2000));
		tick_q.push_back(stick_tick(12'd1249, 12'd2000, 12'd2000, 12'd2000));
		tick_q.push_back(stick_tick(12'd1750, 12'd2000, 12'd2000, 12'd2000));
		tick_q.push_back(stick_tick(12'd1751, 12'd1299, 12'd1199, 12'd1299));
		tick_q.push_back(stick_tick(12'd1700, 12'd1299, 12'd1199, 12'd1299));
		tick_q.push_back(stick_tick(12'd1701, 12'd1300, 12'd1199, 12'd1299));
		tick_q.push_back(stick_tick(12'd1701, 12'd1299, 12'd1199, 12'd1299));
		tick_q.push_back(stick_tick(12'd0, 12'd1299, 12'd1199, 12'd1300));
		tick_q.push_back(stick_tick(12'd2048, 12'd0, 12'd0, 12'd0));
		tick_q.push_back(stick_tick(12'd1024, 12'd0, 12'd1200, 12'd0));
		tick_q.push_back(stick_tick(12'd2047, 12'd2048, 12'd1199, 12'd1700));
		tick_q.push_back(stick_tick(12'd0, 12'd4095, 12'd0, 12'd4095));
		tick_q.push_back(stick_tick(12'd1024, 12'd1024, 12'd0, 12'd1701));
		wait_idle();

		// Longer holds: arm after 61 pose ticks, disarm after 40, seven pairs
		set_config(10'd60, 10'd40, 10'd7);
		@(negedge clk);
		add_ticks(TkArm, 61);
		add_ticks(TkDisarm, 40);
		add_swings(7);
		add_ticks(TkRest, 1);
		wait_idle();

		// Zero holds: the first pose tick arms and, as the cleared disarm count
		// matches the zero hold, disarms too; zero swings fire while both counts are 0
		set_config(10'd0, 10'd0, 10'd0);
		@(negedge clk);
		add_ticks(TkArm, 1);
		add_ticks(TkDisarm, 30);
		wait_idle();

		// Lower the disarm hold while disarmed: the disarm poses that follow
		// run no disarm count, as the block is not armed
		write_reg(sgad_pkg::RegDisarmHold, 10'd5);
		settings_used++;
		@(negedge clk);
		add_ticks(TkDisarm, 3);
		add_ticks(TkRest, 1);
		add_ticks(TkDisarm, 5);
		add_swings(10);
		wait_idle();

		// Random phases with short holds so gestures complete often
		for (int p = 0; p < 5; p++) begin
			case (p)
			0: set_config(10'd1, 10'd1, 10'd1);
			1: begin
				set_config(10'd2, 10'd3, 10'd7);
				write_reg(RegSpare, sgad_pkg::CfgDataW'($urandom_range(0, 1023)));
			end
			default: set_config(sgad_pkg::CfgDataW'($urandom_range(0, 12)),
				sgad_pkg::CfgDataW'($urandom_range(0, 10)),
				sgad_pkg::CfgDataW'($urandom_range(0, 7)));
			endcase
			@(negedge clk);
			// Last phase runs with no idling on either side
			if (p == 4)
				quiet = 1'b1;
			while (tick_q.size() < PhaseTicks)
				add_burst();
			if (p == 2)
				squeeze_req = 1'b1;
			wait_idle();
		end

		repeat (6) @(posedge clk);
		$display("Covered %0d ticks (%0d results) over %0d register settings,",
			ticks_sent, results_seen, settings_used);
		$display("  holds from 0 to 60; events: %0d arm, %0d disarm, %0d calibrate",
			arm_seen, disarm_seen, calib_seen);
		if (err_count == 0 && expected_flags_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/sgad_pkg.sv
rtl/sgad_cfg.sv
rtl/sgad_core.sv
rtl/stick_gesture_arm_disarm_detector.sv
tb/sv/stick_gesture_arm_disarm_detector_tb.sv
